// ===== rtl/core/hbte_pkg.sv =====
// ----------------------------------------------------------------------------
// hbte_pkg
// Shared types, codes and character lookups for the hex / base64 text encoder.
// ----------------------------------------------------------------------------
package hbte_pkg;

	// Mode register codes. Code 3 behaves as pass-through.
	localparam logic [1:0] MODE_PASS = 2'd0;
	localparam logic [1:0] MODE_HEX  = 2'd1;
	localparam logic [1:0] MODE_B64  = 2'd2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

	// What kind of text a queued job turns into.
	typedef enum logic [1:0] {
		KIND_PASS = 2'd0,
		KIND_HEX  = 2'd1,
		KIND_B64  = 2'd2
	} kind_t;

	// One queued job. The data byte, or the first byte of a base64 group,
	// sits in grp[23:16]. pad is the number of '=' characters that close a
	// base64 group (0, 1 or 2).
	typedef struct packed {
		kind_t       kind;
		logic [23:0] grp;
		logic [1:0]  pad;
		logic        last;
	} job_t;

	// Queue status seen by the front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h57 + {4'd0, nib};  // 'a' - 10
		end
		return c;
	endfunction

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		priority if (v < 6'd26) begin
			c = 8'h41 + {2'd0, v};          // 'A'..'Z'
		end else if (v < 6'd52) begin
			c = 8'h47 + {2'd0, v};          // 'a' - 26
		end else if (v < 6'd62) begin
			c = {2'd0, v} - 8'd4;           // '0' - 52
		end else if (v == 6'd62) begin
			c = 8'h2B;                      // '+'
		end else begin
			c = 8'h2F;                      // '/'
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/hex_base64_text_encoder.sv =====
// ----------------------------------------------------------------------------
// hex_base64_text_encoder
// Byte stream to text encoder: pass-through, lowercase hex or padded base64.
// ----------------------------------------------------------------------------
// Bytes come in on a valid/ready channel with a last mark and leave as ASCII
// characters on a second valid/ready channel; the final character of the text
// carries char_last. The mode register (0 pass-through, 1 lowercase hex,
// 2 base64 with '=' padding, 3 acts as pass-through) is written through
// cfg_we/cfg_wdata; the user must do so only while the block is idle, as
// the block does not enforce it. Every write drops a partial base64 group.
// Output runs at one character per cycle from the single output register
// unless out_ready stalls it; a byte gives one character in pass-through,
// two in hex, and a base64 group of three bytes gives four. Input is taken
// every cycle while the job queue (QUEUE_DEPTH entries) has room. A full
// queue holds back every byte, including the first two bytes of a base64
// group that would only be stored, so a stalled output side does reach the
// input. A byte's first character goes from the job queue into the output
// register that drives char_out. No clearing pass after reset.
// ----------------------------------------------------------------------------
module hex_base64_text_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_out,
	output logic       char_last
);
	import hbte_pkg::*;

	job_t       push_job;
	job_t       head_job;
	fifo_stat_t fifo_stat;
	logic       push;
	logic       pop;

	// Front end: mode register, base64 group collection, job creation.
	hbte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last      (last),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_job  (push_job)
	);

	// Job queue decouples byte intake from character output.
	hbte_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (fifo_stat)
	);

	// Back end: one character per cycle into the output register unless stalled.
	hbte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.char_last (char_last)
	);

endmodule

// ===== rtl/core/hbte_front.sv =====
// ----------------------------------------------------------------------------
// hbte_front
// Takes input words, holds partial base64 groups and queues encode jobs.
// ----------------------------------------------------------------------------
module hbte_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                last,
	input  hbte_pkg::fifo_stat_t fifo_stat,
	output logic                push,
	output hbte_pkg::job_t      push_job
);
	import hbte_pkg::*;

	logic [1:0]  mode_q;
	logic [15:0] held_bytes_q;
	logic [1:0]  held_count_q;
	logic        accept;
	logic        absorb;

	assign in_ready = !fifo_stat.full;
	assign accept   = in_valid && in_ready;

	// In base64 mode the first two bytes of a group are only stored, unless last is set.
	assign absorb = (mode_q == MODE_B64) && (held_count_q < 2'd2) && !last;
	assign push   = accept && !absorb;

	always_comb begin
		push_job      = '0;
		push_job.last = last;
		unique case (mode_q)
			MODE_HEX: begin
				push_job.kind = KIND_HEX;
				push_job.grp  = {data_byte, 16'd0};
			end
			MODE_B64: begin
				push_job.kind = KIND_B64;
				unique case (held_count_q)
					2'd0: begin
						push_job.grp = {data_byte, 16'd0};
						push_job.pad = 2'd2;
					end
					2'd1: begin
						push_job.grp = {held_bytes_q[15:8], data_byte, 8'd0};
						push_job.pad = 2'd1;
					end
					default: begin
						push_job.grp = {held_bytes_q, data_byte};
						push_job.pad = 2'd0;
					end
				endcase
			end
			default: begin
				push_job.kind = KIND_PASS;
				push_job.grp  = {data_byte, 16'd0};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_PASS;
			held_bytes_q <= '0;
			held_count_q <= '0;
		end else if (cfg_we) begin
			mode_q       <= cfg_wdata;
			held_bytes_q <= '0;
			held_count_q <= '0;
		end else if (accept) begin
			if (absorb) begin
				if (held_count_q == 2'd0) begin
					held_bytes_q <= {data_byte, 8'd0};
				end else begin
					held_bytes_q <= {held_bytes_q[15:8], data_byte};
				end
				held_count_q <= held_count_q + 2'd1;
			end else begin
				held_bytes_q <= '0;
				held_count_q <= '0;
			end
		end
	end

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q != 2'd3)
		else $error("held byte count out of range");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last && !cfg_we |=> held_count_q == 2'd0)
		else $error("held bytes survive a last word");

endmodule

// ===== rtl/core/hbte_fifo.sv =====
// ----------------------------------------------------------------------------
// hbte_fifo
// Short job queue between the front and the character back end.
// ----------------------------------------------------------------------------
module hbte_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hbte_pkg::job_t       push_job,
	input  logic                 pop,
	output hbte_pkg::job_t       head_job,
	output hbte_pkg::fifo_stat_t stat
);
	import hbte_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head_job   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full && push && !pop |=> stat.full && $stable(wr_ptr_q))
		else $error("job queue overran");

endmodule

// ===== rtl/core/hbte_back.sv =====
// ----------------------------------------------------------------------------
// hbte_back
// Turns the queue head job into characters, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module hbte_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hbte_pkg::job_t       head_job,
	input  hbte_pkg::fifo_stat_t fifo_stat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           char_out,
	output logic                 char_last
);
	import hbte_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] char_q;
	logic       char_last_q;
	logic [1:0] final_idx;
	logic [5:0] sextet;
	logic [7:0] next_char;
	logic       fire;
	logic       at_end;

	always_comb begin
		unique case (head_job.kind)
			KIND_HEX: final_idx = 2'd1;
			KIND_B64: final_idx = 2'd3;
			default:  final_idx = 2'd0;
		endcase
	end

	always_comb begin
		unique case (idx_q)
			2'd0:    sextet = head_job.grp[23:18];
			2'd1:    sextet = head_job.grp[17:12];
			2'd2:    sextet = head_job.grp[11:6];
			default: sextet = head_job.grp[5:0];
		endcase
	end

	always_comb begin
		unique case (head_job.kind)
			KIND_HEX: begin
				next_char = (idx_q == 2'd0) ? hex_char(head_job.grp[23:20])
				                            : hex_char(head_job.grp[19:16]);
			end
			KIND_B64: begin
				if ((idx_q == 2'd2 && head_job.pad == 2'd2) ||
				    (idx_q == 2'd3 && head_job.pad != 2'd0)) begin
					next_char = PAD_CHAR;
				end else begin
					next_char = b64_char(sextet);
				end
			end
			default: next_char = head_job.grp[23:16];
		endcase
	end

	assign at_end    = (idx_q == final_idx);
	assign fire      = !fifo_stat.empty && (!out_valid_q || out_ready);
	assign pop       = fire && at_end;
	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign char_last = char_last_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			char_q      <= next_char;
			char_last_q <= head_job.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
			idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_idx_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> !fifo_stat.empty)
		else $error("character index set without a job in the queue");

endmodule

// ===== test/hex_base64_text_encoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hex_base64_text_encoder_tb
// Self-checking bench for the pass-through / hex / base64 text encoder.
// ----------------------------------------------------------------------------
// Bytes go in with random gaps and characters are taken with random stalls.
// A model of the encoder inside the bench turns every accepted byte into the
// characters it should produce. A checker compares each character word that
// leaves the block with the oldest of those, field by field.
// ----------------------------------------------------------------------------
module hex_base64_text_encoder_tb;

	import hbte_pkg::*;

	// Mode code 3 is not named in the package; the block treats it as
	// pass-through.
	localparam logic [1:0] MODE_ALT_PASS = 2'd3;

	// Character tables, first character in the most significant byte.
	localparam logic [511:0] B64_TEXT =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam logic [127:0] HEX_TEXT = "0123456789abcdef";

	// A byte passes the job queue and the output register, and the job queue
	// is short, so DRAIN_CYCLES is plenty for the block to go quiet.
	localparam int DRAIN_CYCLES = 10;
	localparam int ROUND_WORDS  = 25;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] char_out;
	logic       char_last;

	// Characters still owed by the block, oldest first, as {char_last, char}.
	logic [8:0] pending_chars[$];
	int         error_count;

	// Encoder state as the bench sees it: the mode register and the base64
	// bytes that wait for the rest of their group.
	logic [1:0]  enc_mode;
	logic [15:0] group_bytes;
	logic [1:0]  group_count;

	// When clear, the matching side runs without any gaps or stalls.
	bit src_idle_on;
	bit sink_idle_on;

	hex_base64_text_encoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.char_last (char_last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Encoder model
	// ------------------------------------------------------------------

	function automatic logic [7:0] alphabet_char(input logic [5:0] v);
		return B64_TEXT[(63 - v) * 8 +: 8];
	endfunction

	// Works out the characters that one accepted byte produces and queues
	// them. In base64 mode the first two bytes of a group are only held,
	// unless the slice ends on them; then the group is closed with padding.
	task automatic encode_byte(input logic [7:0] value, input logic is_last);
		logic [23:0] triple;
		logic [7:0]  third_char;
		logic [7:0]  fourth_char;
		case (enc_mode)
			MODE_HEX: begin
				pending_chars.push_back({1'b0, HEX_TEXT[(15 - value[7:4]) * 8 +: 8]});
				pending_chars.push_back({is_last, HEX_TEXT[(15 - value[3:0]) * 8 +: 8]});
			end
			MODE_B64: begin
				if (group_count < 2'd2 && !is_last) begin
					if (group_count == 2'd0) begin
						group_bytes = {value, 8'h00};
					end else begin
						group_bytes[7:0] = value;
					end
					group_count = group_count + 2'd1;
				end else begin
					// Missing bytes of a short group count as zero.
					case (group_count)
						2'd0:    triple = {value, 16'h0000};
						2'd1:    triple = {group_bytes[15:8], value, 8'h00};
						default: triple = {group_bytes, value};
					endcase
					third_char  = (group_count >= 2'd1) ? alphabet_char(triple[11:6]) : PAD_CHAR;
					fourth_char = (group_count >= 2'd2) ? alphabet_char(triple[5:0]) : PAD_CHAR;
					pending_chars.push_back({1'b0, alphabet_char(triple[23:18])});
					pending_chars.push_back({1'b0, alphabet_char(triple[17:12])});
					pending_chars.push_back({1'b0, third_char});
					pending_chars.push_back({is_last, fourth_char});
					group_bytes = 16'h0000;
					group_count = 2'd0;
				end
			end
			default: begin
				pending_chars.push_back({is_last, value});
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Output side: random stalls and the checker
	// ------------------------------------------------------------------

	// After each character word taken, ready may drop for a random hold.
	always @(posedge clk) begin : sink_stall
		int ready_hold;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				ready_hold = sink_idle_on ? $urandom_range(0, 4) : 0;
			end else if (ready_hold > 0) begin
				ready_hold = ready_hold - 1;
			end
			out_ready <= (ready_hold == 0);
		end else begin
			ready_hold = 0;
			out_ready  <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_chars
		logic [8:0] owed;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual char_out %h char_last %b",
					$time, char_out, char_last);
				error_count++;
			end else begin
				owed = pending_chars.pop_front();
				if (char_out !== owed[7:0]) begin
					$display("%0t: char_out expected %h actual %h", $time, owed[7:0], char_out);
					error_count++;
				end
				if (char_last !== owed[8]) begin
					$display("%0t: char_last expected %b actual %b", $time, owed[8], char_last);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offers one byte after a random gap and returns at the edge where it is
	// taken. Valid stays high afterwards, so a back-to-back byte just replaces
	// the payload.
	task automatic send_byte(input logic [7:0] value, input logic is_last);
		int gap;
		gap = src_idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= value;
		last      <= is_last;
		encode_byte(value, is_last);
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	// Stops offering bytes until every owed character has come out. It waits
	// for a clock edge first, so valid is never lowered and raised in one step.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_chars.size() != 0);
	endtask

	// Brings the block to rest. A held base64 byte owes nothing, so a few
	// more cycles pass for anything still in flight.
	task automatic settle();
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A mode write also drops any partial base64 group.
	task automatic write_mode(input logic [1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		enc_mode    = value;
		group_bytes = 16'h0000;
		group_count = 2'd0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Straight out of reset the mode is pass-through.
	task automatic test_reset_pass_through();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hA5, 1'b0);
	endtask

	task automatic test_hex();
		write_mode(MODE_HEX);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h9A, 1'b0);
		send_byte(8'h5C, 1'b1);
	endtask

	// Full group, one-byte and two-byte ends, a full group with no end mark
	// followed by a lone last byte, and the two top alphabet entries.
	task automatic test_base64_groups();
		write_mode(MODE_B64);
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b1);
		send_byte(8'h4D, 1'b1);
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hBF, 1'b1);
	endtask

	// A held base64 byte must be lost on a mode write, and mode 3 copies.
	task automatic test_mode_write();
		send_byte(8'h12, 1'b0);
		write_mode(MODE_B64);
		send_byte(8'h34, 1'b1);
		write_mode(MODE_ALT_PASS);
		send_byte(8'h7E, 1'b0);
		send_byte(8'h81, 1'b1);
	endtask

	// Rounds of slices with random bytes, each round in one mode. Most slices
	// are 1 to 7 bytes ending in a last mark; now and then the mark is moved,
	// and a round may stop mid-group so the next mode write drops it. Two
	// rounds run with no gaps and no stalls at all.
	task automatic test_random_streams();
		logic [1:0] next_mode;
		logic       is_last;
		int         slice_left;
		for (int round = 0; round < 8; round++) begin
			case (round)
				0:       next_mode = MODE_HEX;
				1:       next_mode = MODE_B64;
				2:       next_mode = MODE_PASS;
				3:       next_mode = MODE_B64;
				4:       next_mode = MODE_ALT_PASS;
				5:       next_mode = MODE_B64;
				6:       next_mode = MODE_HEX;
				default: next_mode = MODE_B64;
			endcase
			write_mode(next_mode);
			src_idle_on  = (round != 3 && round != 6);
			sink_idle_on = src_idle_on;
			slice_left   = 0;
			for (int i = 0; i < ROUND_WORDS; i++) begin
				if (slice_left == 0) begin
					slice_left = $urandom_range(1, 7);
				end
				slice_left = slice_left - 1;
				is_last    = (slice_left == 0);
				if ($urandom_range(0, 9) == 0) begin
					is_last = !is_last;
				end
				if (is_last) begin
					slice_left = 0;
				end
				// Let the output side run dry now and then, and mid-round
				// every time.
				if (i == ROUND_WORDS / 2 || $urandom_range(0, 15) == 0) begin
					hold_until_drained();
				end
				send_byte(8'($urandom_range(0, 255)), is_last);
			end
		end
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Run
	// ------------------------------------------------------------------

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = MODE_PASS;
		in_valid     = 1'b0;
		data_byte    = 8'h00;
		last         = 1'b0;
		error_count  = 0;
		enc_mode     = MODE_PASS;
		group_bytes  = 16'h0000;
		group_count  = 2'd0;
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_pass_through();
		test_hex();
		test_base64_groups();
		test_mode_write();
		test_random_streams();
		settle();

		if (error_count == 0 && pending_chars.size() == 0) begin
			$display("PASS hex_base64_text_encoder");
		end else begin
			$display("FAIL hex_base64_text_encoder");
		end
		$finish;
	end

	// The timeout lies far beyond what the whole run needs even with every gap
	// and stall at its longest; 2 ms only trips if the block hangs.
	initial begin
		#2000000;
		$display("FAIL hex_base64_text_encoder");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/hbte_pkg.sv
rtl/core/hbte_front.sv
rtl/core/hbte_fifo.sv
rtl/core/hbte_back.sv
rtl/core/hex_base64_text_encoder.sv
test/hex_base64_text_encoder_tb.sv
